@@ sv/sts_pkg.sv @@
// Shared types and constants for the sorted table search block.
// No dependencies; every other file imports this package.
package sts_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // Item field widths
  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int OUT_W   = CNT_W;

  // Index reported on a miss
  localparam logic [OUT_W-1:0] IDX_NONE = {OUT_W{1'b1}};

  // Function codes of an input item
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Decoded strobes of one accepted item
  typedef struct packed {
    logic append;
    logic clear;
    logic query;
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BS_RD,
    ST_BS_CMP,
    ST_LO_RD,
    ST_LO_CMP,
    ST_HI_RD,
    ST_HI_CMP,
    ST_FIN
  } state_t;

endpackage

@@ sv/sts_if.sv @@
// Valid/ready channel interfaces for commands and search results.
// Depends on sts_pkg for field widths.
interface sts_cmd_if import sts_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [OUT_W-1:0] match_index;
  logic [OUT_W-1:0]        insert_position;
  logic signed [OUT_W-1:0] first_index;
  logic signed [OUT_W-1:0] last_index;

  modport source (output valid, output found, output match_index, output insert_position,
                  output first_index, output last_index, input ready);
  modport sink   (input valid, input found, input match_index, input insert_position,
                  input first_index, input last_index, output ready);
endinterface

@@ sv/sts_store.sv @@
// Table memory with fill count: appends, clears and one registered read port.
// Depends on sts_pkg.
module sts_store import sts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  op_t                       op,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic signed [VALUE_W-1:0] rd_data,
  output logic [CNT_W-1:0]          count
);

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic                      has_room;

  assign has_room = count < CNT_W'(TABLE_DEPTH);

  // Track fill level; drop appends once full
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op.clear) begin
      count <= '0;
    end else if (op.append && has_room) begin
      count <= count + CNT_W'(1);
    end
  end

  // Write at the fill level
  always_ff @(posedge clk) begin
    if (op.append && has_room) begin
      mem[count[ADDR_W-1:0]] <= value;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/sts_seq.sv @@
// Search sequencer: halving search, then widening over the equal run,
// all through one shared comparator and the table read port. Depends on sts_pkg, sts_if.
module sts_seq import sts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  op_t                       op,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]          count,
  input  logic signed [VALUE_W-1:0] rd_data,
  output logic                      ready,
  output logic [ADDR_W-1:0]         rd_addr,
  sts_rsp_if.source                 rsp
);

  state_t                    state, state_next;
  logic signed [VALUE_W-1:0] key;
  logic [CNT_W-1:0]          left;
  logic [CNT_W-1:0]          right_p1;
  logic [ADDR_W-1:0]         mid;
  logic [ADDR_W-1:0]         hit;
  logic [ADDR_W-1:0]         lo;
  logic [ADDR_W-1:0]         hi;
  logic                      found;

  logic [CNT_W:0]            mid_sum;
  logic [ADDR_W-1:0]         mid_calc;
  logic                      range_open;
  logic                      lo_at_start;
  logic                      hi_at_end;
  logic                      cmp_lt;
  logic                      cmp_eq;
  logic                      rsp_free;

  // Shared comparator: table word against the target
  assign cmp_lt = rd_data < key;
  assign cmp_eq = rd_data == key;

  // Midpoint of [left, right_p1 - 1]
  assign mid_sum    = {1'b0, left} + {1'b0, right_p1} - (CNT_W+1)'(1);
  assign mid_calc   = mid_sum[ADDR_W:1];
  assign range_open = left < right_p1;

  assign lo_at_start = lo == '0;
  assign hi_at_end   = (CNT_W'(hi) + CNT_W'(1)) >= count;
  assign rsp_free    = !rsp.valid || rsp.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (op.query) state_next = ST_BS_RD;
      ST_BS_RD:  state_next = range_open ? ST_BS_CMP : ST_FIN;
      ST_BS_CMP: state_next = cmp_eq ? ST_LO_RD : ST_BS_RD;
      ST_LO_RD:  state_next = lo_at_start ? ST_HI_RD : ST_LO_CMP;
      ST_LO_CMP: state_next = cmp_eq ? ST_LO_RD : ST_HI_RD;
      ST_HI_RD:  state_next = hi_at_end ? ST_FIN : ST_HI_CMP;
      ST_HI_CMP: state_next = cmp_eq ? ST_HI_RD : ST_FIN;
      ST_FIN:    if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and read address
  always_comb begin
    ready   = 1'b0;
    rd_addr = mid_calc;
    unique case (state)
      ST_IDLE:  ready = 1'b1;
      ST_BS_RD: rd_addr = mid_calc;
      ST_LO_RD: rd_addr = lo - ADDR_W'(1);
      ST_HI_RD: rd_addr = hi + ADDR_W'(1);
      default:  rd_addr = mid_calc;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search bounds and run limits
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (op.query) begin
          key      <= value;
          left     <= '0;
          right_p1 <= count;
          found    <= 1'b0;
        end
      end
      ST_BS_RD: mid <= mid_calc;
      ST_BS_CMP: begin
        priority if (cmp_eq) begin
          hit   <= mid;
          lo    <= mid;
          hi    <= mid;
          found <= 1'b1;
        end else if (cmp_lt) begin
          left <= CNT_W'(mid) + CNT_W'(1);
        end else begin
          right_p1 <= CNT_W'(mid);
        end
      end
      ST_LO_CMP: if (cmp_eq) lo <= lo - ADDR_W'(1);
      ST_HI_CMP: if (cmp_eq) hi <= hi + ADDR_W'(1);
      default: ;
    endcase
  end

  // Result register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_FIN && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && rsp_free) begin
      rsp.found <= found;
      if (found) begin
        rsp.match_index     <= OUT_W'(hit);
        rsp.insert_position <= OUT_W'(hit);
        rsp.first_index     <= OUT_W'(lo);
        rsp.last_index      <= OUT_W'(hi);
      end else begin
        rsp.match_index     <= IDX_NONE;
        rsp.insert_position <= OUT_W'(left);
        rsp.first_index     <= IDX_NONE;
        rsp.last_index      <= IDX_NONE;
      end
    end
  end

endmodule

@@ sv/sorted_table_search.sv @@
// Top level of the sorted table search: command decode, table store, search sequencer.
// Depends on sts_pkg, sts_if, sts_store, sts_seq.
//
//   channel  dir  payload
//   cmd      in   func, value
//   rsp      out  found, match_index, insert_position, first_index, last_index
//
// Append and clear do not occupy the sequencer and give no result.
// A query holds the input through S halving compares (at most log2 of the depth plus one) and,
// on a hit, W widening reads around it; each compare or read is a read state and a compare state,
// and a miss, or a side whose equal run reaches a table end, stops with a read state alone.
// The result waits in an output register and the next command is taken meanwhile; a query
// that finishes while an older result still waits holds until that transfer.
// Reset clears the fill count and the sequencer; table words are undefined until written.
module sorted_table_search import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sts_cmd_if.sink   cmd,
  sts_rsp_if.source rsp
);

  op_t                       op;
  logic                      accept;
  logic                      seq_ready;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic [CNT_W-1:0]          count;

  // Decode the accepted command
  assign accept    = cmd.valid && seq_ready;
  assign cmd.ready = seq_ready;

  always_comb begin
    op = '0;
    unique case (func_t'(cmd.func))
      FUNC_APPEND: op.append = accept;
      FUNC_QUERY:  op.query  = accept;
      FUNC_CLEAR:  op.clear  = accept;
      FUNC_NONE:   op = '0;
      default:     op = '0;
    endcase
  end

  sts_store u_store (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .value   (cmd.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .count   (count)
  );

  sts_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .value   (cmd.value),
    .count   (count),
    .rd_data (rd_data),
    .ready   (seq_ready),
    .rd_addr (rd_addr),
    .rsp     (rsp)
  );

endmodule

@@ sim/sts_checker.sv @@
// Checker for the sorted table search: watches both channels, predicts each query answer,
// and compares every result transfer field by field. Depends on sts_pkg and sts_if.
module sts_checker import sts_pkg::*; (
  input  logic clk,
  input  logic rst,
  sts_cmd_if   cmd,
  sts_rsp_if   rsp,
  output int   mismatches,
  output int   open_queries
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                    found;
    logic signed [OUT_W-1:0] match_index;
    logic [OUT_W-1:0]        insert_position;
    logic signed [OUT_W-1:0] first_index;
    logic signed [OUT_W-1:0] last_index;
  } answer_t;

  // Shadow copy of the table and its fill level
  logic signed [VALUE_W-1:0] words [TABLE_DEPTH];
  int                        fill_count = 0;

  answer_t answer_q[$];
  int      err_count  = 0;
  int      queued     = 0;
  int      result_num = 0;

  assign mismatches   = err_count;
  assign open_queries = queued;

  task automatic log_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s got %0d expected %0d", result_num, name, got, want));
  endtask

  // Halving search over the filled part, then widen around a hit to the equal run
  function automatic answer_t search_words(logic signed [VALUE_W-1:0] target);
    int      lo;
    int      hi;
    int      mid;
    int      hit;
    int      run_lo;
    int      run_hi;
    answer_t ans;
    lo  = 0;
    hi  = fill_count - 1;
    hit = -1;
    while (lo <= hi && hit < 0) begin
      mid = lo + (hi - lo) / 2;
      if (words[mid] < target) lo = mid + 1;
      else if (words[mid] > target) hi = mid - 1;
      else hit = mid;
    end
    if (hit >= 0) begin
      run_lo = hit;
      while (run_lo > 0 && words[run_lo-1] == target) run_lo--;
      run_hi = hit;
      while (run_hi < fill_count - 1 && words[run_hi+1] == target) run_hi++;
      ans.found           = 1'b1;
      ans.insert_position = OUT_W'(hit);
    end else begin
      run_lo              = -1;
      run_hi              = -1;
      ans.found           = 1'b0;
      ans.insert_position = OUT_W'(lo);
    end
    ans.match_index = OUT_W'(hit);
    ans.first_index = OUT_W'(run_lo);
    ans.last_index  = OUT_W'(run_hi);
    return ans;
  endfunction

  task automatic apply_command(func_t code, logic signed [VALUE_W-1:0] value);
    case (code)
      FUNC_APPEND: begin
        // drop appends once the table is full
        if (fill_count < TABLE_DEPTH) begin
          words[fill_count] = value;
          fill_count++;
        end
      end
      FUNC_QUERY: answer_q.insert(answer_q.size(), search_words(value));
      FUNC_CLEAR: fill_count = 0;
      default: ;
    endcase
  endtask

  task automatic check_answer();
    answer_t want;
    result_num++;
    if (answer_q.size() == 0) begin
      log_mismatch($sformatf("result %0d arrived with no query outstanding", result_num));
    end else begin
      want = answer_q.pop_front();
      check_field("found", rsp.found, want.found);
      check_field("match_index", rsp.match_index, want.match_index);
      check_field("insert_position", rsp.insert_position, want.insert_position);
      check_field("first_index", rsp.first_index, want.first_index);
      check_field("last_index", rsp.last_index, want.last_index);
    end
  endtask

  // Retire results before taking new commands, so a result in the same cycle
  // is always matched against an older query
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) check_answer();
      if (cmd.valid && cmd.ready) apply_command(func_t'(cmd.func), cmd.value);
    end
    queued <= answer_q.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the sorted table search testbench: clock, reset, command stimulus, result stalls.
// Depends on sts_pkg, sts_if, sorted_table_search and sts_checker.
module testbench import sts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_EVERY   = 1200;
  localparam int HOLD_CYCLES  = 300;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct {
    func_t                     func;
    logic signed [VALUE_W-1:0] value;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   mismatch_count;
  int   open_queries;

  sts_cmd_if cmd ();
  sts_rsp_if rsp ();

  sorted_table_search u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  sts_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rsp          (rsp),
    .mismatches   (mismatch_count),
    .open_queries (open_queries)
  );

  always #1 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Command list and the table contents as the generator expects them
  cmd_item_t                 cmd_items[$];
  logic signed [VALUE_W-1:0] loaded_vals[$];
  logic signed [VALUE_W-1:0] last_append;
  int                        counted_items = 0;

  task automatic push_cmd(func_t code, logic signed [VALUE_W-1:0] value);
    cmd_item_t item;
    item.func  = code;
    item.value = value;
    cmd_items.insert(cmd_items.size(), item);
    if (code != FUNC_NONE) counted_items++;
    if (code == FUNC_CLEAR) loaded_vals.delete();
    if (code == FUNC_APPEND) begin
      last_append = value;
      if (loaded_vals.size() < TABLE_DEPTH) loaded_vals.insert(loaded_vals.size(), value);
    end
  endtask

  // Mostly hits and near misses, some extremes and fully random targets
  function automatic logic signed [VALUE_W-1:0] pick_target();
    int                        k;
    logic signed [VALUE_W-1:0] base;
    k = $urandom_range(0, 99);
    if (loaded_vals.size() == 0 || k >= 80) return $signed($urandom());
    if (k >= 70) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    base = loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
    if (k < 50) return base;
    return ($urandom_range(0, 1) == 0) ? base - 1 : base + 1;
  endfunction

  // Append n ascending values; dup_pct sets how often a value repeats
  task automatic append_run(int n, int unsigned step_cap, int dup_pct);
    longint            lo_bound;
    longint            hi_bound;
    longint            cur;
    longint unsigned   r;
    lo_bound = longint'(VAL_MIN);
    hi_bound = longint'(VAL_MAX) - longint'(n) * longint'(step_cap);
    if (hi_bound < lo_bound) hi_bound = lo_bound;
    r   = {$urandom(), $urandom()};
    cur = lo_bound + longint'(r % ($unsigned(hi_bound - lo_bound) + 1));
    if ($urandom_range(0, 3) == 0) cur = lo_bound;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(1, 100) > dup_pct) cur += $urandom_range(1, step_cap);
      if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
      push_cmd(FUNC_APPEND, cur[VALUE_W-1:0]);
    end
  endtask

  task automatic run_episode();
    int          n;
    int          dup_pct;
    int unsigned step_cap;
    // Usually start from an empty table; sometimes pile onto the old contents
    if (loaded_vals.size() > 200 || $urandom_range(0, 9) != 0)
      push_cmd(FUNC_CLEAR, $signed($urandom()));
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 160);
    dup_pct = ($urandom_range(0, 24) == 0) ? 100 : $urandom_range(0, 50);
    case ($urandom_range(0, 3))
      0:       step_cap = 1;
      1:       step_cap = 16;
      2:       step_cap = 1 << 16;
      default: step_cap = 32'h7fff_ffff / (n + 1);
    endcase
    if (step_cap == 0) step_cap = 1;
    append_run(n, step_cap, dup_pct);
    // Occasional out-of-order append leaves the table unsorted
    if ($urandom_range(0, 19) == 0) push_cmd(FUNC_APPEND, $signed($urandom()));
    repeat ($urandom_range(1, 14)) begin
      if ($urandom_range(0, 19) == 0) push_cmd(FUNC_NONE, $signed($urandom()));
      push_cmd(FUNC_QUERY, pick_target());
    end
  endtask

  // Fill past capacity once so the extra appends are dropped
  task automatic fill_to_capacity();
    push_cmd(FUNC_CLEAR, $signed($urandom()));
    append_run(TABLE_DEPTH + $urandom_range(1, 6), 1 << 21, 20);
    push_cmd(FUNC_QUERY, last_append);
    push_cmd(FUNC_QUERY, VAL_MAX);
    repeat (24) push_cmd(FUNC_QUERY, pick_target());
  endtask

  task automatic build_directed();
    // Empty table, then extremes and an equal run
    push_cmd(FUNC_QUERY, 32'sd0);
    push_cmd(FUNC_NONE, 32'sh5555_5555);
    push_cmd(FUNC_APPEND, VAL_MIN);
    push_cmd(FUNC_APPEND, -32'sd7);
    push_cmd(FUNC_APPEND, -32'sd7);
    push_cmd(FUNC_APPEND, -32'sd7);
    push_cmd(FUNC_APPEND, 32'sd100);
    push_cmd(FUNC_APPEND, VAL_MAX);
    push_cmd(FUNC_QUERY, VAL_MIN);
    push_cmd(FUNC_QUERY, VAL_MAX);
    push_cmd(FUNC_QUERY, -32'sd7);
    push_cmd(FUNC_QUERY, -32'sd8);
    push_cmd(FUNC_QUERY, 32'sd101);
    push_cmd(FUNC_QUERY, 32'sd0);
    push_cmd(FUNC_QUERY, VAL_MAX - 1);
    push_cmd(FUNC_QUERY, VAL_MIN + 1);
    push_cmd(FUNC_NONE, 32'shaaaa_aaaa);
    push_cmd(FUNC_QUERY, 32'sd100);
    // Clear empties the table
    push_cmd(FUNC_CLEAR, 32'sd0);
    push_cmd(FUNC_QUERY, -32'sd7);
    push_cmd(FUNC_APPEND, 32'sd5);
    push_cmd(FUNC_QUERY, 32'sd5);
    push_cmd(FUNC_QUERY, 32'sd4);
    push_cmd(FUNC_QUERY, 32'sd6);
  endtask

  // Receiver: stall pattern of its own, with a long hold-off now and then
  initial begin
    int seg;
    int pct;
    int since_hold;
    since_hold = 0;
    rsp.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (since_hold >= HOLD_EVERY) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        since_hold = 0;
      end
      seg = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0:       pct = 100;
        1:       pct = 60;
        default: pct = 20;
      endcase
      repeat (seg) begin
        rsp.ready <= ($urandom_range(1, 100) <= pct);
        @(posedge clk);
        since_hold++;
      end
    end
  end

  // Sender: build the command list, reset, then drive in bursts with gaps
  initial begin
    int idx;
    int burst;
    int gap;
    bit filled_once;
    cmd.valid <= 1'b0;
    cmd.func  <= FUNC_APPEND;
    cmd.value <= '0;
    rst       <= 1'b1;

    filled_once = 1'b0;
    build_directed();
    while (counted_items < ITEM_TARGET) begin
      if (!filled_once && counted_items >= 400) begin
        fill_to_capacity();
        filled_once = 1'b1;
      end else begin
        run_episode();
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < cmd_items.size()) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && idx < cmd_items.size()) begin
        cmd.valid <= 1'b1;
        cmd.func  <= cmd_items[idx].func;
        cmd.value <= cmd_items[idx].value;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd.valid <= 1'b0;

    // Drain outstanding queries, then watch for stray results
    @(posedge clk);
    while (open_queries != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && open_queries == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
